### design/safu_pkg.sv
// ----------------------------------------------------------------------------
// safu_pkg
// Shared types and constants of the slot allocating fifo unit: item layouts,
// operation and status codes, and the sizes of the slot pool.
// ----------------------------------------------------------------------------
package safu_pkg;

   // pool size and the widths that follow from it
   localparam int SLOTS     = 16;
   localparam int SLOT_W    = (SLOTS > 2) ? $clog2(SLOTS) : 1;
   localparam int OCC_W     = $clog2(SLOTS + 1);

   // fixed field widths of the items
   localparam int KIND_W    = 2;
   localparam int POS_W     = 4;
   localparam int SLOT_FW   = 4;
   localparam int COUNT_W   = 5;
   localparam int STATUS_W  = 2;

   // width of head pointer plus peek position
   localparam int IDX_SUM_W = ((SLOT_W > POS_W) ? SLOT_W : POS_W) + 1;

   // operation codes
   localparam logic [KIND_W-1:0] KIND_PUSH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PEEK = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   // request item
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  position;
   } req_type;

   // response item
   typedef struct packed {
      logic [SLOT_FW-1:0]  slot;
      logic [COUNT_W-1:0]  count;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

### design/slot_allocating_fifo_unit.sv
// ----------------------------------------------------------------------------
// slot_allocating_fifo_unit
// Pool of buffer slots with a lowest-free allocator and a fifo ring of the
// claimed slot numbers; push, pop and peek, one result item per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_data carry one operation per item (push, pop or
//   peek with a position). rsp_valid/rsp_stall/rsp_data return exactly one
//   item per request: the slot number, the count of used slots after the
//   operation, and a status code.
//   A request is held in the request register; then the allocator, ring
//   access and pointer update run in one pass into the response register.
//   Throughput is one item per cycle while rsp_stall is low; the single
//   pass over the state is the only step, so consecutive operations see
//   each other's updates directly.
//   When rsp_stall is high the response register holds, the request register
//   holds behind it, and req_stall rises once both are full.
//   Reset (synchronous, active high) empties the pool: all slots free, both
//   ring pointers and the count at zero. Ring entries are not cleared; only
//   entries written by a push are ever read.
// ----------------------------------------------------------------------------
module slot_allocating_fifo_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  safu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output safu_pkg::rsp_type rsp_data
);
   import safu_pkg::*;

   // request stage
   logic    req_valid_ff, req_valid_in;
   req_type req_ff;

   // response stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // pool state
   logic [SLOTS-1:0]  used_map_ff, used_map_in;
   logic [SLOT_W-1:0] ring_ff [SLOTS];
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;

   // datapath
   logic                 advance;
   logic                 fire;
   logic                 ring_we;
   logic [SLOT_W-1:0]    free_idx;
   logic                 is_full;
   logic [IDX_SUM_W-1:0] idx_sum;
   logic [SLOT_W-1:0]    peek_idx;
   logic [SLOT_W-1:0]    slot_val;
   logic [STATUS_W-1:0]  status_val;

   // handshake
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign req_valid_in = req_stall ? 1'b1 : req_valid;
   assign rsp_valid_in = advance ? req_valid_ff : 1'b1;

   // lowest free slot, priority to slot zero
   always_comb begin
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_map_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
   end

   assign is_full = (occ_ff == OCC_W'(SLOTS));

   // ring index for peek, wraps once since position stays below the pool size
   always_comb begin
      idx_sum = IDX_SUM_W'(head_ff) + IDX_SUM_W'(req_ff.position);
      if (idx_sum >= IDX_SUM_W'(SLOTS)) begin
         idx_sum = idx_sum - IDX_SUM_W'(SLOTS);
      end
      peek_idx = idx_sum[SLOT_W-1:0];
   end

   // operation decode and state update
   always_comb begin
      used_map_in = used_map_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      occ_in      = occ_ff;
      ring_we     = 1'b0;
      slot_val    = '0;
      status_val  = ST_OK;
      case (req_ff.kind)
         KIND_PUSH: begin
            if (is_full) begin
               status_val = ST_FULL;
            end else begin
               slot_val              = free_idx;
               used_map_in[free_idx] = 1'b1;
               ring_we               = fire;
               tail_in = (tail_ff == SLOT_W'(SLOTS - 1)) ? '0 : tail_ff + 1'b1;
               occ_in  = occ_ff + 1'b1;
            end
         end
         KIND_POP: begin
            if (occ_ff == '0) begin
               status_val = ST_EMPTY;
            end else begin
               slot_val              = ring_ff[head_ff];
               used_map_in[slot_val] = 1'b0;
               head_in = (head_ff == SLOT_W'(SLOTS - 1)) ? '0 : head_ff + 1'b1;
               occ_in  = occ_ff - 1'b1;
            end
         end
         KIND_PEEK: begin
            if (OCC_W'(req_ff.position) >= occ_ff
                || {1'b0, req_ff.position} >= (POS_W + 1)'(SLOTS)) begin
               status_val = ST_RANGE;
            end else begin
               slot_val = ring_ff[peek_idx];
            end
         end
         default: begin
            status_val = ST_OK;
         end
      endcase
   end

   // response fields
   always_comb begin
      rsp_in.slot   = SLOT_FW'(slot_val);
      rsp_in.count  = COUNT_W'(occ_in);
      rsp_in.status = status_val;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         used_map_ff  <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            used_map_ff <= used_map_in;
            head_ff     <= head_in;
            tail_ff     <= tail_in;
            occ_ff      <= occ_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_ff <= req_data;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
      end
      if (ring_we) begin
         ring_ff[tail_ff] <= free_idx;
      end
   end

endmodule

### design/safu_checker.sv
// ----------------------------------------------------------------------------
// safu_checker
// Port-level checks of the slot allocating fifo unit, bound to the top level.
// ----------------------------------------------------------------------------
module safu_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input safu_pkg::rsp_type rsp_data
);
   import safu_pkg::*;

   // a stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response item changed while stalled");

   // count never exceeds the pool
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.count <= COUNT_W'(SLOTS))
      else $error("count above pool size");

   // a full push reports a full pool
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL |-> rsp_data.count == COUNT_W'(SLOTS))
      else $error("full status with free slots");

   // empty pop reports zero count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.count == '0)
      else $error("empty status with slots in use");

   // errors carry slot zero
   a_err_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.slot == '0)
      else $error("error item with nonzero slot");

endmodule

bind slot_allocating_fifo_unit safu_checker u_safu_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
